/* design/bptc_pkg.sv */
// Package: shared types, constants and register indexes of the barometer compensation block.
package bptc_pkg;

   localparam int NUM_CELLS  = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] REG_TEMP_COEFFS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_MID    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_HIGH   = 2'd3;

   // calibration words as held in the configuration registers
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } bptc_coef_type;

   // state handed from one divider cell to the next
   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] nq;
      logic [63:0] dvs;
      logic        neg;
      logic        dz;
      logic [31:0] temp;
      logic [31:0] fine;
   } bptc_div_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic [31:0] press;
      logic        dz;
   } bptc_rsp_type;

endpackage

/* design/bptc_front.sv */
// Module: temperature compensation and pressure terms up to the divider operands.
module bptc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   run,
   input  logic                   in_valid,
   input  logic [19:0]            adc_p,
   input  logic [19:0]            adc_t,
   input  bptc_pkg::bptc_coef_type coef,
   output logic                   out_valid,
   output bptc_pkg::bptc_div_type  out_state
);

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic [19:0] adcp;
   } carry_type;

   logic [7:0] vld_ff;
   logic       out_valid_ff;

   // stage 1
   logic signed [17:0] ta;
   logic signed [16:0] td;
   logic signed [33:0] aprod;
   logic signed [33:0] dd;
   logic [31:0] s1_aprod_ff, s1_dd_ff;
   logic [19:0] s1_adcp_ff;
   // stage 2
   logic signed [31:0] ash, ddsh;
   logic signed [35:0] bprod;
   logic [31:0] s2_a_ff, s2_b_ff;
   logic [19:0] s2_adcp_ff;
   // stage 3
   logic signed [31:0] bsh;
   logic [31:0] s3_fine_ff;
   logic [19:0] s3_adcp_ff;
   // stage 4
   logic [31:0] f5;
   logic signed [31:0] tsh;
   logic [32:0] s4_v1_ff;
   carry_type   s4_c_ff;
   // stage 5
   logic signed [65:0] sq;
   logic signed [48:0] v1p5, v1p2;
   logic [63:0] s5_sq_ff;
   logic [48:0] s5_v1p5_ff, s5_v1p2_ff;
   carry_type   s5_c_ff;
   // stage 6
   logic signed [79:0] m6, m3;
   logic signed [63:0] m3sh;
   logic [63:0] v2_in, v1x_in;
   logic [63:0] s6_v2_ff, s6_v1x_ff;
   carry_type   s6_c_ff;
   // stage 7
   logic [63:0] sum47;
   logic [79:0] m1;
   logic [20:0] pd;
   logic [63:0] s7_m1_ff, s7_pn_ff;
   carry_type   s7_c_ff;
   // stage 8
   logic signed [63:0] dsh;
   logic [75:0] m3125;
   logic [63:0] s8_n_ff, s8_d_ff;
   carry_type   s8_c_ff;
   // stage 9
   bptc_pkg::bptc_div_type s9_ff;

   always_comb begin
      ta    = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
      td    = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, coef.t1});
      aprod = ta * $signed(coef.t2);
      dd    = td * td;

      ash   = $signed(s1_aprod_ff) >>> 11;
      ddsh  = $signed(s1_dd_ff) >>> 12;
      bprod = $signed(ddsh[19:0]) * $signed(coef.t3);

      bsh   = $signed(s2_b_ff) >>> 14;

      f5    = s3_fine_ff + {s3_fine_ff[29:0], 2'b00} + 32'd128;
      tsh   = $signed(f5) >>> 8;

      sq    = $signed(s4_v1_ff) * $signed(s4_v1_ff);
      v1p5  = $signed(s4_v1_ff) * $signed(coef.p5);
      v1p2  = $signed(s4_v1_ff) * $signed(coef.p2);

      m6     = $signed(s5_sq_ff) * $signed(coef.p6);
      m3     = $signed(s5_sq_ff) * $signed(coef.p3);
      m3sh   = $signed(m3[63:0]) >>> 8;
      v2_in  = m6[63:0] + ({{15{s5_v1p5_ff[48]}}, s5_v1p5_ff} << 17)
             + ({{48{coef.p4[15]}}, coef.p4} << 35);
      v1x_in = m3sh + ({{15{s5_v1p2_ff[48]}}, s5_v1p2_ff} << 12);

      sum47 = 64'h0000_8000_0000_0000 + s6_v1x_ff;
      m1    = sum47 * coef.p1;
      pd    = 21'd1048576 - {1'b0, s6_c_ff.adcp};

      dsh   = $signed(s7_m1_ff) >>> 33;
      m3125 = s7_pn_ff * 12'd3125;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (run) begin
         vld_ff       <= {vld_ff[6:0], in_valid};
         out_valid_ff <= vld_ff[7];
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         s1_aprod_ff <= aprod[31:0];
         s1_dd_ff    <= dd[31:0];
         s1_adcp_ff  <= adc_p;

         s2_a_ff    <= ash;
         s2_b_ff    <= bprod[31:0];
         s2_adcp_ff <= s1_adcp_ff;

         s3_fine_ff <= s2_a_ff + bsh;
         s3_adcp_ff <= s2_adcp_ff;

         s4_v1_ff     <= {s3_fine_ff[31], s3_fine_ff} - 33'd128000;
         s4_c_ff.temp <= tsh;
         s4_c_ff.fine <= s3_fine_ff;
         s4_c_ff.adcp <= s3_adcp_ff;

         s5_sq_ff   <= sq[63:0];
         s5_v1p5_ff <= v1p5;
         s5_v1p2_ff <= v1p2;
         s5_c_ff    <= s4_c_ff;

         s6_v2_ff  <= v2_in;
         s6_v1x_ff <= v1x_in;
         s6_c_ff   <= s5_c_ff;

         s7_m1_ff <= m1[63:0];
         s7_pn_ff <= {12'd0, pd, 31'd0} - s6_v2_ff;
         s7_c_ff  <= s6_c_ff;

         s8_n_ff <= m3125[63:0];
         s8_d_ff <= dsh;
         s8_c_ff <= s7_c_ff;

         // split into magnitudes and a sign for the restoring divider
         s9_ff.rem  <= '0;
         s9_ff.nq   <= s8_n_ff[63] ? (64'd0 - s8_n_ff) : s8_n_ff;
         s9_ff.dvs  <= s8_d_ff[63] ? (64'd0 - s8_d_ff) : s8_d_ff;
         s9_ff.neg  <= s8_n_ff[63] ^ s8_d_ff[63];
         s9_ff.dz   <= (s8_d_ff == 64'd0);
         s9_ff.temp <= s8_c_ff.temp;
         s9_ff.fine <= s8_c_ff.fine;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_state = s9_ff;

endmodule

/* design/bptc_div_cell.sv */
// Module: one restoring-division cell, settles one quotient bit per request.
module bptc_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  run,
   input  logic                  in_valid,
   input  bptc_pkg::bptc_div_type in_state,
   output logic                  out_valid,
   output bptc_pkg::bptc_div_type out_state
);

   logic [64:0] trial;
   logic [64:0] diff;
   logic        valid_ff;
   bptc_pkg::bptc_div_type state_ff, state_in;

   always_comb begin
      trial    = {in_state.rem, in_state.nq[63]};
      diff     = trial - {1'b0, in_state.dvs};
      state_in = in_state;
      // keep the difference when the divisor fits, else keep the shifted remainder
      state_in.rem = diff[64] ? trial[63:0] : diff[63:0];
      state_in.nq  = {in_state.nq[62:0], ~diff[64]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (run) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

/* design/bptc_back.sv */
// Module: quotient sign fixup and second-order pressure correction.
module bptc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   run,
   input  logic                   in_valid,
   input  bptc_pkg::bptc_div_type  in_state,
   input  bptc_pkg::bptc_coef_type coef,
   output logic                   out_valid,
   output bptc_pkg::bptc_rsp_type  out_rsp
);

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic        dz;
      logic [63:0] q;
   } carry_type;

   logic [5:0] vld_ff;

   carry_type p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   // stage 2
   logic signed [63:0] s;
   logic signed [66:0] x1p;
   logic signed [79:0] y8p;
   logic [63:0] p2_x1_ff, p2_s_ff, p2_y8_ff;
   // stage 3
   logic [63:0] pp0;
   logic [63:0] p3_acc_ff, p3_x1_ff, p3_s_ff, p3_y8_ff;
   // stage 4
   logic [63:0] pa;
   logic [63:0] p4_acc_ff, p4_y8_ff;
   logic [31:0] p4_x1hi_ff, p4_slo_ff;
   // stage 5
   logic [63:0] pb;
   logic [63:0] p5_acc_ff, p5_y8_ff;
   // stage 6
   logic signed [63:0] msh, ysh, ssh;
   logic [63:0] sum, pf;
   bptc_pkg::bptc_rsp_type p6_ff;

   always_comb begin
      s   = $signed(p1_ff.q) >>> 13;
      x1p = $signed(coef.p9) * $signed(s[50:0]);
      y8p = $signed(coef.p8) * $signed(p1_ff.q);

      pp0 = p2_x1_ff[31:0] * p2_s_ff[31:0];
      pa  = p3_x1_ff[31:0] * p3_s_ff[63:32];
      pb  = p4_x1hi_ff * p4_slo_ff;

      msh = $signed(p5_acc_ff) >>> 25;
      ysh = $signed(p5_y8_ff) >>> 19;
      sum = p5_ff.q + msh + ysh;
      ssh = $signed(sum) >>> 8;
      pf  = ssh + {{44{coef.p7[15]}}, coef.p7, 4'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (run) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         p1_ff.temp <= in_state.temp;
         p1_ff.fine <= in_state.fine;
         p1_ff.dz   <= in_state.dz;
         p1_ff.q    <= in_state.neg ? (64'd0 - in_state.nq) : in_state.nq;

         p2_ff    <= p1_ff;
         p2_x1_ff <= x1p[63:0];
         p2_s_ff  <= s;
         p2_y8_ff <= y8p[63:0];

         // low 64 bits of x1 * s from three 32-bit partial products
         p3_ff     <= p2_ff;
         p3_acc_ff <= pp0;
         p3_x1_ff  <= p2_x1_ff;
         p3_s_ff   <= p2_s_ff;
         p3_y8_ff  <= p2_y8_ff;

         p4_ff      <= p3_ff;
         p4_acc_ff  <= p3_acc_ff + {pa[31:0], 32'd0};
         p4_x1hi_ff <= p3_x1_ff[63:32];
         p4_slo_ff  <= p3_s_ff[31:0];
         p4_y8_ff   <= p3_y8_ff;

         p5_ff     <= p4_ff;
         p5_acc_ff <= p4_acc_ff + {pb[31:0], 32'd0};
         p5_y8_ff  <= p4_y8_ff;

         p6_ff.temp  <= p5_ff.temp;
         p6_ff.fine  <= p5_ff.fine;
         p6_ff.dz    <= p5_ff.dz;
         p6_ff.press <= p5_ff.dz ? 32'd0 : pf[31:0];
      end
   end

   assign out_valid = vld_ff[5];
   assign out_rsp   = p6_ff;

endmodule

/* design/baro_temp_pressure_compensation.sv */
// Top level: barometer temperature and pressure compensation pipeline with divider cell chain.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_ready   req_raw_pressure, req_raw_temperature
//  rsp      out        rsp_valid / rsp_ready   rsp_temperature_centi, rsp_fine_temperature,
//                                              rsp_pressure_q24_8, rsp_divide_by_zero
//  csr      in         csr_wr_en               csr_index, csr_wdata
//
// One request enters per cycle while the pipeline is not held; each result passes 9 front stages,
// 64 divider cells settling one quotient bit each, 6 correction stages and the output register.
// Reset is synchronous and clears all valid bits; coefficient registers return to zero.
// A result waiting at the output does not block intake: one more result lands in a skid
// register, and only while that skid register is full does the whole pipeline hold.
module baro_temp_pressure_compensation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [19:0]                        req_raw_pressure,
   input  logic [19:0]                        req_raw_temperature,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_temperature_centi,
   output logic signed [31:0]                 rsp_fine_temperature,
   output logic [31:0]                        rsp_pressure_q24_8,
   output logic                               rsp_divide_by_zero,
   input  logic                               csr_wr_en,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [bptc_pkg::CSR_DATA_W-1:0] temp_coeffs_ff, press_low_ff, press_mid_ff, press_high_ff;
   bptc_pkg::bptc_coef_type coef;

   logic run;

   logic [bptc_pkg::NUM_CELLS:0] cell_valid;
   bptc_pkg::bptc_div_type       cell_state [bptc_pkg::NUM_CELLS+1];

   logic                   back_valid;
   bptc_pkg::bptc_rsp_type back_rsp;

   logic                   rsp_valid_ff, skid_valid_ff;
   bptc_pkg::bptc_rsp_type rsp_ff, skid_ff;

   // Configuration: plain writes; the user must write only while idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_mid_ff   <= '0;
         press_high_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bptc_pkg::REG_TEMP_COEFFS: temp_coeffs_ff <= csr_wdata;
            bptc_pkg::REG_PRESS_LOW:   press_low_ff   <= csr_wdata;
            bptc_pkg::REG_PRESS_MID:   press_mid_ff   <= csr_wdata;
            bptc_pkg::REG_PRESS_HIGH:  press_high_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign coef.t1 = temp_coeffs_ff[15:0];
   assign coef.t2 = temp_coeffs_ff[31:16];
   assign coef.t3 = temp_coeffs_ff[47:32];
   assign coef.p1 = press_low_ff[15:0];
   assign coef.p2 = press_low_ff[31:16];
   assign coef.p3 = press_low_ff[47:32];
   assign coef.p4 = press_mid_ff[15:0];
   assign coef.p5 = press_mid_ff[31:16];
   assign coef.p6 = press_mid_ff[47:32];
   assign coef.p7 = press_high_ff[15:0];
   assign coef.p8 = press_high_ff[31:16];
   assign coef.p9 = press_high_ff[47:32];

   // Advance every stage together unless the skid register holds a result.
   assign run       = ~skid_valid_ff;
   assign req_ready = run;

   bptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .in_valid  (req_valid),
      .adc_p     (req_raw_pressure),
      .adc_t     (req_raw_temperature),
      .coef      (coef),
      .out_valid (cell_valid[0]),
      .out_state (cell_state[0])
   );

   // Divider: one cell per quotient bit, most significant first.
   for (genvar gi = 0; gi < bptc_pkg::NUM_CELLS; gi++) begin : g_cell
      bptc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .run       (run),
         .in_valid  (cell_valid[gi]),
         .in_state  (cell_state[gi]),
         .out_valid (cell_valid[gi+1]),
         .out_state (cell_state[gi+1])
      );
   end

   bptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .run       (run),
      .in_valid  (cell_valid[bptc_pkg::NUM_CELLS]),
      .in_state  (cell_state[bptc_pkg::NUM_CELLS]),
      .coef      (coef),
      .out_valid (back_valid),
      .out_rsp   (back_rsp)
   );

   // Output register and skid: drop the pipeline result into the output when it is free,
   // otherwise park it in the skid register; refill the output from skid when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (run) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= back_valid;
         end else begin
            skid_valid_ff <= back_valid;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (run) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_ff <= back_rsp;
         end else begin
            skid_ff <= back_rsp;
         end
      end else if (rsp_ready) begin
         rsp_ff <= skid_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = rsp_ff.temp;
   assign rsp_fine_temperature  = rsp_ff.fine;
   assign rsp_pressure_q24_8    = rsp_ff.press;
   assign rsp_divide_by_zero    = rsp_ff.dz;

   // A parked result always sits behind a shown one.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while the output is empty");

   // A parked result is not lost while the output is not taken.
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("skid result dropped without a take");

   // Hold the divider chain while stalled.
   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      (!run && !rsp_ready) |=> $stable(cell_valid))
      else $error("divider chain moved during a stall");

endmodule
